>>> rtl/core/rgb422_pkg.sv
`default_nettype none

package rgb422_pkg;

    localparam int PIX_W   = 8;
    localparam int COEF_W  = 18;
    localparam int PROD_W  = COEF_W + PIX_W + 1;
    localparam int SUM_W   = PROD_W;
    localparam int FRAC_W  = 16;
    localparam int MODE_W  = 2;
    localparam int HEIGHT_W = 13;
    localparam int CFG_W   = HEIGHT_W;
    localparam int NUM_COEF = 9;

    typedef logic [PIX_W-1:0]          pix_t;
    typedef logic signed [COEF_W-1:0]  coef_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic [MODE_W-1:0]         mode_t;
    typedef logic [HEIGHT_W-1:0]       height_t;
    typedef logic [CFG_W-1:0]          cfg_data_t;
    typedef logic                      cfg_index_t;

    // register indexes
    localparam cfg_index_t REG_MATRIX_MODE  = 1'b0;
    localparam cfg_index_t REG_FRAME_HEIGHT = 1'b1;

    // matrix_mode codes; the unused code falls back to BT.601
    localparam mode_t MODE_AUTO  = 2'd0;
    localparam mode_t MODE_BT601 = 2'd1;
    localparam mode_t MODE_BT709 = 2'd2;

    localparam height_t AUTO_HEIGHT_LIMIT = 13'd720;

    // coefficient order: yr yg yb ur ug ub vr vg vb
    localparam int C_YR = 0;
    localparam int C_YG = 1;
    localparam int C_YB = 2;
    localparam int C_UR = 3;
    localparam int C_UG = 4;
    localparam int C_UB = 5;
    localparam int C_VR = 6;
    localparam int C_VG = 7;
    localparam int C_VB = 8;

    localparam coef_t COEF_601 [NUM_COEF] = '{
        18'sd16829,  18'sd33039,  18'sd6416,
        -18'sd9714,  -18'sd19070, 18'sd28784,
        18'sd28784,  -18'sd24103, -18'sd4681
    };

    localparam coef_t COEF_709 [NUM_COEF] = '{
        18'sd11966,  18'sd40254,  18'sd4064,
        -18'sd6596,  -18'sd22188, 18'sd28784,
        18'sd28784,  -18'sd26145, -18'sd2639
    };

    localparam sum_t LUMA_OFFSET  = sum_t'(16 * 65536);
    localparam sum_t CHROMA_BIAS  = sum_t'(128 * 65536);
    localparam sum_t HALF_LSB     = sum_t'(32768);

endpackage

`default_nettype wire

>>> rtl/core/rgb422_if.sv
`default_nettype none

interface rgb422_pair_if;
    import rgb422_pkg::*;

    logic valid;
    logic ready;
    pix_t red_first;
    pix_t green_first;
    pix_t blue_first;
    pix_t red_second;
    pix_t green_second;
    pix_t blue_second;

    modport source (
        output valid, red_first, green_first, blue_first,
               red_second, green_second, blue_second,
        input  ready
    );

    modport sink (
        input  valid, red_first, green_first, blue_first,
               red_second, green_second, blue_second,
        output ready
    );
endinterface

interface rgb422_group_if;
    import rgb422_pkg::*;

    logic valid;
    logic ready;
    pix_t chroma_blue;
    pix_t luma_first;
    pix_t chroma_red;
    pix_t luma_second;

    modport source (
        output valid, chroma_blue, luma_first, chroma_red, luma_second,
        input  ready
    );

    modport sink (
        input  valid, chroma_blue, luma_first, chroma_red, luma_second,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/rgb_pair_to_ycbcr_422.sv
// An accepted pixel pair passes four register stages (average/select, coefficient
// multiply, sum with offset, round/clamp) to its 4:2:2 word at the output.
// One pair per cycle is taken while the output is not stalled; each stage advances
// on its own valid/ready, so a stalled output fills bubbles first and loses nothing.
// Reset (rst_n, async, active low) empties the pipeline and sets matrix_mode
// and frame_height to 0 (auto mode, BT.601 until a height of 720 or more is written).
`default_nettype none

module rgb_pair_to_ycbcr_422 (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_wr_en,
    input  wire rgb422_pkg::cfg_index_t  cfg_index,
    input  wire rgb422_pkg::cfg_data_t   cfg_wr_data,
    rgb422_pair_if.sink                  pair,
    rgb422_group_if.source               group
);
    import rgb422_pkg::*;

    // ---------------- configuration ----------------
    mode_t   matrix_mode_reg;
    height_t frame_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_mode_reg  <= MODE_AUTO;
            frame_height_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_MATRIX_MODE:  matrix_mode_reg  <= cfg_wr_data[MODE_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wr_data[HEIGHT_W-1:0];
                default:          ;
            endcase
        end
    end

    logic sel709;
    assign sel709 = (matrix_mode_reg == MODE_BT709) ||
                    ((matrix_mode_reg == MODE_AUTO) &&
                     (frame_height_reg >= AUTO_HEIGHT_LIMIT));

    // ---------------- stage enables ----------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    assign en4 = !v4_reg || group.ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign pair.ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= pair.valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // ---------------- stage 1: latch pixels, pair average, matrix select ----------------
    pix_t r0_reg, g0_reg, b0_reg, r1_reg, g1_reg, b1_reg;
    pix_t ra_reg, ga_reg, ba_reg;
    logic sel709_reg;
    logic [PIX_W:0] ra_next, ga_next, ba_next;

    // rounded average: (a + b + 1) >> 1
    assign ra_next = ({1'b0, pair.red_first}   + {1'b0, pair.red_second}   + 1'b1);
    assign ga_next = ({1'b0, pair.green_first} + {1'b0, pair.green_second} + 1'b1);
    assign ba_next = ({1'b0, pair.blue_first}  + {1'b0, pair.blue_second}  + 1'b1);

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            r0_reg     <= pair.red_first;
            g0_reg     <= pair.green_first;
            b0_reg     <= pair.blue_first;
            r1_reg     <= pair.red_second;
            g1_reg     <= pair.green_second;
            b1_reg     <= pair.blue_second;
            ra_reg     <= ra_next[PIX_W:1];
            ga_reg     <= ga_next[PIX_W:1];
            ba_reg     <= ba_next[PIX_W:1];
            sel709_reg <= sel709;
        end
    end

    // ---------------- stage 2: coefficient multiplies ----------------
    coef_t coef [NUM_COEF];
    prod_t y0r_reg, y0g_reg, y0b_reg;
    prod_t y1r_reg, y1g_reg, y1b_reg;
    prod_t ur_reg, ug_reg, ub_reg;
    prod_t vr_reg, vg_reg, vb_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_COEF; i++)
        begin
            coef[i] = sel709_reg ? COEF_709[i] : COEF_601[i];
        end
    end

    // widen both operands so the product keeps all of its bits
    function automatic prod_t mul(input coef_t c, input pix_t p);
        mul = prod_t'(c) * prod_t'($signed({1'b0, p}));
    endfunction

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            y0r_reg <= mul(coef[C_YR], r0_reg);
            y0g_reg <= mul(coef[C_YG], g0_reg);
            y0b_reg <= mul(coef[C_YB], b0_reg);
            y1r_reg <= mul(coef[C_YR], r1_reg);
            y1g_reg <= mul(coef[C_YG], g1_reg);
            y1b_reg <= mul(coef[C_YB], b1_reg);
            ur_reg  <= mul(coef[C_UR], ra_reg);
            ug_reg  <= mul(coef[C_UG], ga_reg);
            ub_reg  <= mul(coef[C_UB], ba_reg);
            vr_reg  <= mul(coef[C_VR], ra_reg);
            vg_reg  <= mul(coef[C_VG], ga_reg);
            vb_reg  <= mul(coef[C_VB], ba_reg);
        end
    end

    // ---------------- stage 3: sums with offset ----------------
    sum_t y0_sum_reg, y1_sum_reg, cb_sum_reg, cr_sum_reg;

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            y0_sum_reg <= y0r_reg + y0g_reg + y0b_reg + LUMA_OFFSET;
            y1_sum_reg <= y1r_reg + y1g_reg + y1b_reg + LUMA_OFFSET;
            cb_sum_reg <= ur_reg + ug_reg + ub_reg + CHROMA_BIAS;
            cr_sum_reg <= vr_reg + vg_reg + vb_reg + CHROMA_BIAS;
        end
    end

    // ---------------- stage 4: round at half, clamp to a byte ----------------
    function automatic pix_t round_clamp(input sum_t s);
        sum_t                  t;
        logic [SUM_W-FRAC_W-1:0] q;
        t = s + HALF_LSB;
        q = t[SUM_W-1:FRAC_W];
        if (s[SUM_W-1])
            round_clamp = '0;
        else if (|q[SUM_W-FRAC_W-1:PIX_W])
            round_clamp = '1;
        else
            round_clamp = q[PIX_W-1:0];
    endfunction

    pix_t cb_reg, y0_reg, cr_reg, y1_reg;

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            cb_reg <= round_clamp(cb_sum_reg);
            y0_reg <= round_clamp(y0_sum_reg);
            cr_reg <= round_clamp(cr_sum_reg);
            y1_reg <= round_clamp(y1_sum_reg);
        end
    end

    assign group.valid       = v4_reg;
    assign group.chroma_blue = cb_reg;
    assign group.luma_first  = y0_reg;
    assign group.chroma_red  = cr_reg;
    assign group.luma_second = y1_reg;

    // ---------------- assertions ----------------
    a_ready_follows_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        group.ready |-> pair.ready
    ) else $error("input stalled while output drains");

    a_chroma_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        group.valid |-> (group.chroma_blue >= 8'd16 && group.chroma_blue <= 8'd240 &&
                         group.chroma_red  >= 8'd16 && group.chroma_red  <= 8'd240)
    ) else $error("chroma outside studio range");

    a_luma_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        group.valid |-> (group.luma_first  >= 8'd16 && group.luma_first  <= 8'd235 &&
                         group.luma_second >= 8'd16 && group.luma_second <= 8'd235)
    ) else $error("luma outside studio range");

endmodule

`default_nettype wire
